// ----- hdl/pwi_pkg.sv -----
// ----------------------------------------------------------------------------
// pwi_pkg
// Shared types and constants of the windowed-integral PID controller.
// ----------------------------------------------------------------------------
package pwi_pkg;

  localparam int WIN_LEN   = 8;
  localparam int IDX_W     = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;

  localparam int ERR_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 32;
  localparam int DRIVE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam int FRAC_DROP = 4;
  localparam int WSUM_W    = ERR_W + $clog2(WIN_LEN);
  localparam int DIFF_W    = ERR_W + 1;
  localparam int P_PROD_W  = ERR_W + GAIN_W;
  localparam int D_PROD_W  = DIFF_W + GAIN_W;
  localparam int I_PROD_W  = WSUM_W + GAIN_W;
  localparam int P_W       = P_PROD_W - FRAC_DROP;
  localparam int D_W       = D_PROD_W - FRAC_DROP;
  localparam int I_W       = I_PROD_W - FRAC_DROP;
  localparam int CMP_W     = (I_W > LIM_W) ? I_W : LIM_W;
  localparam int TOT_W     = LIM_W + 2;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sd65536;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  localparam logic signed [LIM_W-1:0] INTEG_MAX_RST = 32'sd3277;
  localparam logic signed [LIM_W-1:0] INTEG_MIN_RST = -32'sd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_INTEGRAL_MAX = 3'd3,
    REG_INTEGRAL_MIN = 3'd4
  } reg_index_t;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_FLUSH  = 1'b1
  } command_t;

endpackage

// ----- hdl/pid_windowed_integral.sv -----
// ----------------------------------------------------------------------------
// pid_windowed_integral
// PID controller with the integral taken over a moving window of errors.
//
// Input channel (in_valid / in_stall): in_command selects an update, which
// carries in_error_sample (Q8.8), or a flush, which empties the window and
// gives no result. Result channel (out_valid / out_stall): out_drive, Q16,
// clamped above at 1.0. The user must write gains and integral limits on
// the cfg_ port only while the block is idle; the block does not enforce it.
// One item is taken every cycle while in_stall is low. The window sits in
// a RAM read and written at the slot being replaced in the transfer cycle;
// a running window sum is updated from the read data, so no window loop
// limits the rate. A result reaches out_valid through five registered
// stages (RAM read, sum and P/D multiply, I multiply, I clamp, final add
// and clamp).
// A stalled receiver holds the output register; stages behind it fill up
// and in_stall rises only when every stage holds an item.
// Reset empties the window through per-entry valid bits, zeroes the sum and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_windowed_integral
  import pwi_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic signed [ERR_W-1:0]    in_error_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DRIVE_W-1:0]  out_drive,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  logic signed [GAIN_W-1:0] prop_gain_r;
  logic signed [GAIN_W-1:0] integ_gain_r;
  logic signed [GAIN_W-1:0] deriv_gain_r;
  logic signed [LIM_W-1:0]  integral_max_r;
  logic signed [LIM_W-1:0]  integral_min_r;

  logic                     rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic                     accept;
  logic                     is_flush;
  logic [IDX_W-1:0]         newest_r;
  logic [IDX_W-1:0]         slot;
  logic [WIN_LEN-1:0]       wvalid_r;
  logic signed [ERR_W-1:0]  prev_r;
  logic [ERR_W-1:0]         ram_rdata;

  logic                     v1_r, cmd1_r, ov1_r;
  logic signed [ERR_W-1:0]  err1_r, prev1_r;
  logic signed [ERR_W-1:0]  old1;
  logic signed [DIFF_W-1:0] diff1;
  logic signed [P_PROD_W-1:0] p_prod;
  logic signed [D_PROD_W-1:0] d_prod;
  logic signed [WSUM_W-1:0] sum_r, sum_nxt;

  logic                     v2_r;
  logic signed [P_W-1:0]    p2_r;
  logic signed [D_W-1:0]    d2_r;
  logic signed [I_PROD_W-1:0] i_prod;

  logic                     v3_r;
  logic signed [P_W-1:0]    p3_r;
  logic signed [D_W-1:0]    d3_r;
  logic signed [I_W-1:0]    i3_r;
  logic signed [CMP_W-1:0]  i_ext, max_ext, min_ext;
  logic signed [LIM_W-1:0]  i_cl;

  logic                     v4_r;
  logic signed [P_W-1:0]    p4_r;
  logic signed [D_W-1:0]    d4_r;
  logic signed [LIM_W-1:0]  i4_r;
  logic signed [TOT_W-1:0]  total;
  logic signed [DRIVE_W-1:0] total_cl;

  logic                     out_v_r;
  logic signed [DRIVE_W-1:0] drive_r;

  assign rdy_out  = !out_v_r || !out_stall;
  assign rdy4     = !v4_r || rdy_out;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;
  assign is_flush = (command_t'(in_command) == CMD_FLUSH);

  assign slot = (newest_r == IDX_W'(WIN_LEN - 1)) ? '0 : newest_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= '0;
      integ_gain_r   <= '0;
      deriv_gain_r   <= '0;
      integral_max_r <= INTEG_MAX_RST;
      integral_min_r <= INTEG_MIN_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PROP_GAIN:    prop_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_MAX: integral_max_r <= cfg_data[LIM_W-1:0];
        REG_INTEGRAL_MIN: integral_min_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  pwi_ram #(
    .WIDTH (ERR_W),
    .DEPTH (WIN_LEN)
  ) u_window (
    .clk   (clk),
    .we    (accept && !is_flush),
    .waddr (slot),
    .wdata (in_error_sample),
    .re    (accept),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // window pointer, entry valid bits and last stored sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      wvalid_r <= '0;
      prev_r   <= '0;
    end else if (accept) begin
      if (is_flush) begin
        newest_r <= '0;
        wvalid_r <= '0;
        prev_r   <= '0;
      end else begin
        newest_r       <= slot;
        wvalid_r[slot] <= 1'b1;
        prev_r         <= in_error_sample;
      end
    end
  end

  // stage 1: running sum, P and D products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1_r  <= in_command;
      err1_r  <= in_error_sample;
      prev1_r <= prev_r;
      ov1_r   <= wvalid_r[slot];
    end
  end

  assign old1    = ov1_r ? $signed(ram_rdata) : '0;
  assign sum_nxt = sum_r - WSUM_W'(old1) + WSUM_W'(err1_r);
  assign diff1   = DIFF_W'(err1_r) - DIFF_W'(prev1_r);
  assign p_prod  = P_PROD_W'(prop_gain_r) * P_PROD_W'(err1_r);
  assign d_prod  = D_PROD_W'(deriv_gain_r) * D_PROD_W'(diff1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (v1_r && rdy2) begin
      sum_r <= (command_t'(cmd1_r) == CMD_FLUSH) ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r && (command_t'(cmd1_r) == CMD_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      p2_r <= p_prod[P_PROD_W-1:FRAC_DROP];
      d2_r <= d_prod[D_PROD_W-1:FRAC_DROP];
    end
  end

  // stage 2: I product
  assign i_prod = I_PROD_W'(integ_gain_r) * I_PROD_W'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      p3_r <= p2_r;
      d3_r <= d2_r;
      i3_r <= i_prod[I_PROD_W-1:FRAC_DROP];
    end
  end

  // stage 3: I clamp, upper limit first
  assign i_ext   = CMP_W'(i3_r);
  assign max_ext = CMP_W'(integral_max_r);
  assign min_ext = CMP_W'(integral_min_r);

  always_comb begin
    if (i_ext > max_ext) begin
      i_cl = integral_max_r;
    end else if (i_ext < min_ext) begin
      i_cl = integral_min_r;
    end else begin
      i_cl = i_ext[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      p4_r <= p3_r;
      d4_r <= d3_r;
      i4_r <= i_cl;
    end
  end

  // stage 4: sum of terms and drive clamp
  assign total = TOT_W'(p4_r) + TOT_W'(i4_r) + TOT_W'(d4_r);

  always_comb begin
    if (total > TOT_W'(DRIVE_MAX)) begin
      total_cl = DRIVE_MAX;
    end else if (total < TOT_W'(DRIVE_MIN)) begin
      total_cl = DRIVE_MIN;
    end else begin
      total_cl = total[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_out) begin
      out_v_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v4_r) begin
      drive_r <= total_cl;
    end
  end

  assign out_valid = out_v_r;
  assign out_drive = drive_r;

endmodule

// ----- hdl/pwi_ram.sv -----
// ----------------------------------------------------------------------------
// pwi_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module pwi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/pwi_checker.sv -----
// ----------------------------------------------------------------------------
// pwi_checker
// Port-level checks of the windowed-integral PID controller.
// ----------------------------------------------------------------------------
module pwi_checker
  import pwi_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [DRIVE_W-1:0]  out_drive
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive))
    else $error("stalled result not held");

  a_drive_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive <= DRIVE_MAX)
    else $error("drive above 1.0");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output drains");

endmodule

bind pid_windowed_integral pwi_checker u_pwi_checker (.*);
